// ===== rtl/core/dghc_pkg.sv =====
// ----------------------------------------------------------------------------
// dghc_pkg
// shared types and constants for the datagram header check and gap detector
// ----------------------------------------------------------------------------
package dghc_pkg;

	localparam int unsigned MAX_PAYLOAD_BYTES_DEF  = 1436;
	localparam int unsigned MAX_DATAGRAM_BYTES_DEF = 1500;

	localparam int unsigned POS_W = 11;

	localparam logic [POS_W-1:0] HDR_BYTES = 11'd24;
	localparam logic [POS_W-1:0] POS_MAX   = 11'd2047;

	// header byte offsets
	localparam logic [POS_W-1:0] OFS_VERSION = 11'd4;
	localparam logic [POS_W-1:0] OFS_TYPE    = 11'd5;
	localparam logic [POS_W-1:0] OFS_FLAGS   = 11'd6;
	localparam logic [POS_W-1:0] OFS_STREAM  = 11'd8;
	localparam logic [POS_W-1:0] OFS_SEQ     = 11'd12;
	localparam logic [POS_W-1:0] OFS_LEN     = 11'd20;

	localparam logic [31:0] MAGIC_VALUE   = 32'h5155_4331;
	localparam logic [7:0]  VERSION_VALUE = 8'd1;
	localparam logic [7:0]  TYPE_DATA     = 8'd4;
	localparam logic [7:0]  TYPE_PING     = 8'd7;
	localparam logic [7:0]  TYPE_CRYPT_LO = 8'd4;
	localparam logic [7:0]  TYPE_CRYPT_HI = 8'd8;

	localparam int unsigned TDATA_W = 264;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_BAD_HDR = 2'd2,
		ST_BAD_LEN = 2'd3
	} status_t;

	typedef struct packed {
		logic        is_verdict;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [7:0]  packet_type;
		logic [7:0]  header_flags;
		logic [31:0] stream_ident;
		logic [63:0] sequence_number;
		logic [10:0] payload_length;
		logic        gap_found;
		logic [63:0] gap_first;
		logic [63:0] gap_last;
		logic        pong_request;
	} result_t;

	// results offered by the parser for the item in the input register
	typedef struct packed {
		logic valid;
		logic pay;
		logic ver;
	} req_t;

endpackage

// ===== rtl/core/dghc_parse.sv =====
// ----------------------------------------------------------------------------
// dghc_parse
// header parse state, payload decryption and datagram verdict
// ----------------------------------------------------------------------------
module dghc_parse
	import dghc_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD_BYTES  = MAX_PAYLOAD_BYTES_DEF,
	parameter int unsigned MAX_DATAGRAM_BYTES = MAX_DATAGRAM_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  logic [7:0] byte_s1,
	input  logic       last_s1,
	input  logic [7:0] key,
	input  logic       consume,
	output req_t       req,
	output result_t    pay_res,
	output result_t    ver_res
);

	logic [POS_W-1:0] pos_q;
	logic [31:0]      magic_q;
	logic [7:0]       version_q;
	logic [7:0]       type_q;
	logic [7:0]       flags_q;
	logic [31:0]      stream_q;
	logic [63:0]      seq_q;
	logic [31:0]      length_q;
	logic [63:0]      next_seq_q;

	logic [POS_W-1:0] pos_nx;
	logic [31:0]      magic_nx;
	logic [7:0]       version_nx;
	logic [7:0]       type_nx;
	logic [7:0]       flags_nx;
	logic [31:0]      stream_nx;
	logic [63:0]      seq_nx;
	logic [31:0]      length_nx;
	logic             in_range;
	logic             is_hdr;
	logic             crypt;
	status_t          status;
	logic             data_ok;

	assign in_range = {5'd0, pos_q} < 16'(MAX_DATAGRAM_BYTES);
	assign is_hdr   = pos_q < HDR_BYTES;
	assign crypt    = (type_q >= TYPE_CRYPT_LO) && (type_q <= TYPE_CRYPT_HI);

	always_comb begin
		magic_nx   = magic_q;
		version_nx = version_q;
		type_nx    = type_q;
		flags_nx   = flags_q;
		stream_nx  = stream_q;
		seq_nx     = seq_q;
		length_nx  = length_q;
		pos_nx     = pos_q;
		if (in_range) begin
			pos_nx = (pos_q == POS_MAX) ? POS_MAX : pos_q + 11'd1;
			if (is_hdr) begin
				priority if (pos_q < OFS_VERSION) begin
					magic_nx = {magic_q[23:0], byte_s1};
				end else if (pos_q == OFS_VERSION) begin
					version_nx = byte_s1;
				end else if (pos_q == OFS_TYPE) begin
					type_nx = byte_s1;
				end else if (pos_q == OFS_FLAGS) begin
					flags_nx = byte_s1;
				end else if (pos_q < OFS_STREAM) begin
					// reserved byte
				end else if (pos_q < OFS_SEQ) begin
					stream_nx = {stream_q[23:0], byte_s1};
				end else if (pos_q < OFS_LEN) begin
					seq_nx = {seq_q[55:0], byte_s1};
				end else begin
					length_nx = {length_q[23:0], byte_s1};
				end
			end
		end
	end

	always_comb begin
		if (pos_nx < HDR_BYTES) begin
			status = ST_SHORT;
		end else if (magic_nx != MAGIC_VALUE || version_nx != VERSION_VALUE) begin
			status = ST_BAD_HDR;
		end else if (length_nx != {21'd0, pos_nx - HDR_BYTES}
				|| length_nx > 32'(MAX_PAYLOAD_BYTES)) begin
			status = ST_BAD_LEN;
		end else begin
			status = ST_OK;
		end
	end

	assign data_ok = (status == ST_OK) && (type_nx == TYPE_DATA);

	always_comb begin
		pay_res = '0;
		pay_res.payload_byte = byte_s1 ^ (crypt ? key : 8'd0);

		ver_res = '0;
		ver_res.is_verdict = 1'b1;
		ver_res.status     = status;
		if (status == ST_OK) begin
			ver_res.packet_type     = type_nx;
			ver_res.header_flags    = flags_nx;
			ver_res.stream_ident    = stream_nx;
			ver_res.sequence_number = seq_nx;
			ver_res.payload_length  = length_nx[10:0];
			ver_res.pong_request    = (type_nx == TYPE_PING);
			if (type_nx == TYPE_DATA && seq_nx > next_seq_q) begin
				ver_res.gap_found = 1'b1;
				ver_res.gap_first = next_seq_q;
				ver_res.gap_last  = seq_nx - 64'd1;
			end
		end
	end

	assign req.valid = valid_s1;
	assign req.pay   = in_range && !is_hdr;
	assign req.ver   = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			magic_q    <= '0;
			version_q  <= '0;
			type_q     <= '0;
			flags_q    <= '0;
			stream_q   <= '0;
			seq_q      <= '0;
			length_q   <= '0;
			next_seq_q <= 64'd1;
		end else if (consume) begin
			if (last_s1) begin
				pos_q     <= '0;
				magic_q   <= '0;
				version_q <= '0;
				type_q    <= '0;
				flags_q   <= '0;
				stream_q  <= '0;
				seq_q     <= '0;
				length_q  <= '0;
				if (data_ok) begin
					next_seq_q <= seq_nx + 64'd1;
				end
			end else begin
				pos_q     <= pos_nx;
				magic_q   <= magic_nx;
				version_q <= version_nx;
				type_q    <= type_nx;
				flags_q   <= flags_nx;
				stream_q  <= stream_nx;
				seq_q     <= seq_nx;
				length_q  <= length_nx;
			end
		end
	end

endmodule

// ===== rtl/core/dghc_outq.sv =====
// ----------------------------------------------------------------------------
// dghc_outq
// two-entry result register queue, takes up to two results per cycle
// ----------------------------------------------------------------------------
module dghc_outq
	import dghc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  result_t pay_res,
	input  result_t ver_res,
	input  logic    out_ready,
	output logic    consume,
	output logic    out_valid,
	output result_t head
);

	result_t    ent_q [2];
	result_t    ent_nx [2];
	logic [1:0] cnt_q;
	logic [1:0] cnt_nx;
	logic [1:0] free;
	logic [1:0] need;
	logic [1:0] idx;
	logic       pop;

	assign out_valid = cnt_q != 2'd0;
	assign head      = ent_q[0];
	assign pop       = out_valid && out_ready;
	assign free      = 2'd2 - cnt_q + {1'b0, pop};
	assign need      = {1'b0, req.pay} + {1'b0, req.ver};
	assign consume   = req.valid && (need <= free);

	always_comb begin
		ent_nx[0] = ent_q[0];
		ent_nx[1] = ent_q[1];
		if (pop) begin
			ent_nx[0] = ent_q[1];
		end
		idx = cnt_q - {1'b0, pop};
		if (consume && req.pay) begin
			ent_nx[idx[0]] = pay_res;
			idx = idx + 2'd1;
		end
		if (consume && req.ver) begin
			ent_nx[idx[0]] = ver_res;
			idx = idx + 2'd1;
		end
		cnt_nx = idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		ent_q[0] <= ent_nx[0];
		ent_q[1] <= ent_nx[1];
	end

endmodule

// ===== rtl/core/datagram_header_check_gap_detect_top.sv =====
// input register: an accepted byte is held there until the result queue takes its first result item
// throughput: one byte per cycle with no input stall while the output is ready;
//   the two items of a final payload byte fit in the two-entry result queue
// reset: asynchronous; parse state clears, next expected sequence is one,
//   cipher key is zero
// ----------------------------------------------------------------------------
// datagram_header_check_gap_detect_top
// byte-stream datagram header check, payload decryption and sequence gap report
// ----------------------------------------------------------------------------
module datagram_header_check_gap_detect_top
	import dghc_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD_BYTES  = MAX_PAYLOAD_BYTES_DEF,
	parameter int unsigned MAX_DATAGRAM_BYTES = MAX_DATAGRAM_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // rx_byte
	input  logic               s_axis_tlast,  // end_of_datagram
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// payload_byte, status, packet_type, header_flags, stream_ident,
	// sequence_number, payload_length, gap_found, gap_first, gap_last,
	// pong_request, zero pad
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tlast   // is_verdict
);

	logic [7:0] key_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       consume;
	req_t       req;
	result_t    pay_res;
	result_t    ver_res;
	result_t    head;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				key_q <= cfg_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	dghc_parse #(
		.MAX_PAYLOAD_BYTES  (MAX_PAYLOAD_BYTES),
		.MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1),
		.key      (key_q),
		.consume  (consume),
		.req      (req),
		.pay_res  (pay_res),
		.ver_res  (ver_res)
	);

	dghc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.pay_res   (pay_res),
		.ver_res   (ver_res),
		.out_ready (m_axis_tready),
		.consume   (consume),
		.out_valid (m_axis_tvalid),
		.head      (head)
	);

	assign m_axis_tlast = head.is_verdict;
	assign m_axis_tdata = {1'b0, head.pong_request, head.gap_last, head.gap_first,
		head.gap_found, head.payload_length, head.sequence_number,
		head.stream_ident, head.header_flags, head.packet_type, head.status,
		head.payload_byte};

`ifndef SYNTH
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted item not held in input register");

	a_bad_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && head.is_verdict && head.status != ST_OK
		|-> !head.gap_found && !head.pong_request)
		else $error("failed verdict carries gap or pong");

	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && head.gap_found |-> head.gap_first <= head.gap_last)
		else $error("gap range reversed");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !head.is_verdict
		|-> head.status == ST_OK && !head.gap_found && !head.pong_request)
		else $error("payload item carries verdict fields");
`endif

endmodule

// ===== tb/sv/datagram_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datagram_verdict_checker
// watches the key writes, the byte input and the result output of the
// datagram header checker, predicts every payload and verdict item from the
// accepted bytes and compares each result item field by field, oldest first
// ----------------------------------------------------------------------------
module datagram_verdict_checker
	import dghc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // rx_byte
	input  logic               s_axis_tlast,  // end_of_datagram
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// payload_byte, status, packet_type, header_flags, stream_ident,
	// sequence_number, payload_length, gap_found, gap_first, gap_last,
	// pong_request, zero pad
	input  logic [TDATA_W-1:0] m_axis_tdata,
	input  logic               m_axis_tlast,  // is_verdict
	output int                 items_awaited,
	output int                 mismatch_total
);

	logic [7:0]       key;
	logic [POS_W-1:0] byte_pos;
	logic [31:0]      magic_acc;
	logic [7:0]       version_acc;
	logic [7:0]       type_acc;
	logic [7:0]       flags_acc;
	logic [31:0]      stream_acc;
	logic [63:0]      seq_acc;
	logic [31:0]      length_acc;
	logic [63:0]      next_seq;
	result_t          awaited_results[$];
	int               mismatches = 0;

	assign mismatch_total = mismatches;

	task automatic clear_header();
		byte_pos    = '0;
		magic_acc   = '0;
		version_acc = '0;
		type_acc    = '0;
		flags_acc   = '0;
		stream_acc  = '0;
		seq_acc     = '0;
		length_acc  = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		result_t          r;
		logic [POS_W-1:0] count;
		status_t          st;
		count = byte_pos;
		if (byte_pos < MAX_DATAGRAM_BYTES_DEF) begin
			if (byte_pos < HDR_BYTES) begin
				if (byte_pos < OFS_VERSION)
					magic_acc = {magic_acc[23:0], b};
				else if (byte_pos == OFS_VERSION)
					version_acc = b;
				else if (byte_pos == OFS_TYPE)
					type_acc = b;
				else if (byte_pos == OFS_FLAGS)
					flags_acc = b;
				else if (byte_pos >= OFS_STREAM && byte_pos < OFS_SEQ)
					stream_acc = {stream_acc[23:0], b};
				else if (byte_pos >= OFS_SEQ && byte_pos < OFS_LEN)
					seq_acc = {seq_acc[55:0], b};
				else if (byte_pos >= OFS_LEN)
					length_acc = {length_acc[23:0], b};
			end else begin
				r = '0;
				if (type_acc >= TYPE_CRYPT_LO && type_acc <= TYPE_CRYPT_HI)
					r.payload_byte = b ^ key;
				else
					r.payload_byte = b;
				awaited_results.push_back(r);
			end
			count = (byte_pos < POS_MAX) ? byte_pos + 1'b1 : POS_MAX;
		end
		byte_pos = count;

		if (last) begin
			r = '0;
			r.is_verdict = 1'b1;
			if (count < HDR_BYTES)
				st = ST_SHORT;
			else if (magic_acc != MAGIC_VALUE || version_acc != VERSION_VALUE)
				st = ST_BAD_HDR;
			else if (length_acc != {21'd0, count - HDR_BYTES} ||
					length_acc > MAX_PAYLOAD_BYTES_DEF)
				st = ST_BAD_LEN;
			else
				st = ST_OK;
			r.status = st;
			if (st == ST_OK) begin
				r.packet_type     = type_acc;
				r.header_flags    = flags_acc;
				r.stream_ident    = stream_acc;
				r.sequence_number = seq_acc;
				r.payload_length  = length_acc[10:0];
				if (type_acc == TYPE_DATA) begin
					if (seq_acc > next_seq) begin
						r.gap_found = 1'b1;
						r.gap_first = next_seq;
						r.gap_last  = seq_acc - 64'd1;
					end
					next_seq = seq_acc + 64'd1;
				end
				r.pong_request = (type_acc == TYPE_PING);
			end
			awaited_results.push_back(r);
			clear_header();
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 60)
				$display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	task automatic compare_result(input logic [TDATA_W-1:0] d, input logic verdict);
		result_t want;
		if (awaited_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 60)
				$display("%0t ns: item with none expected, expected none got tlast %b tdata %h",
					$time, verdict, d);
		end else begin
			want = awaited_results.pop_front();
			check_field("is_verdict", want.is_verdict, verdict);
			check_field("payload_byte", want.payload_byte, d[7:0]);
			check_field("status", want.status, d[9:8]);
			check_field("packet_type", want.packet_type, d[17:10]);
			check_field("header_flags", want.header_flags, d[25:18]);
			check_field("stream_ident", want.stream_ident, d[57:26]);
			check_field("sequence_number", want.sequence_number, d[121:58]);
			check_field("payload_length", want.payload_length, d[132:122]);
			check_field("gap_found", want.gap_found, d[133]);
			check_field("gap_first", want.gap_first, d[197:134]);
			check_field("gap_last", want.gap_last, d[261:198]);
			check_field("pong_request", want.pong_request, d[262]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key = '0;
			next_seq = 64'd1;
			clear_header();
			awaited_results.delete();
			items_awaited <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				key = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				parse_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				compare_result(m_axis_tdata, m_axis_tlast);
			items_awaited <= awaited_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives datagrams byte by byte into the header checker under bursty input
// and a stalling output, changes the cipher key between phases and reports
// the verdict from the checker's mismatch count
// ----------------------------------------------------------------------------
module tb_top;
	import dghc_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [7:0]         cfg_data = 8'h00;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = 8'h00;  // rx_byte
	logic               s_axis_tlast = 1'b0;   // end_of_datagram
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	// payload_byte, status, packet_type, header_flags, stream_ident,
	// sequence_number, payload_length, gap_found, gap_first, gap_last,
	// pong_request, zero pad
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tlast;           // is_verdict
	int                 items_awaited;
	int                 mismatch_total;

	logic [7:0]  frame_q[$];
	logic [63:0] seq_track = 64'd1;
	int          burst_left = 0;
	int          random_items = 0;
	int          stall_mode = 0;
	int          stall_left = 0;
	int          stall_period = 2;
	int          stall_phase = 0;

	datagram_header_check_gap_detect_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	datagram_verdict_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.items_awaited  (items_awaited),
		.mismatch_total (mismatch_total)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// output back-pressure, switching between stall patterns
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode   = $urandom_range(0, 4);
			stall_left   = $urandom_range(30, 300);
			stall_period = $urandom_range(2, 5);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			1: m_axis_tready <= $urandom_range(0, 1);
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			3: begin
				stall_phase = (stall_phase + 1) % stall_period;
				m_axis_tready <= (stall_phase == 0);
			end
			default: m_axis_tready <= 1'b1;
		endcase
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (items_awaited != 0) @(posedge clk);
	endtask

	task automatic write_key(input logic [7:0] k);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic make_header(input logic [31:0] magic, input logic [7:0] version,
			input logic [7:0] ptype, input logic [7:0] flags, input logic [31:0] stream,
			input logic [63:0] seq, input logic [31:0] len_field);
		int i;
		frame_q.delete();
		for (i = 3; i >= 0; i--)
			frame_q.push_back(magic[8*i +: 8]);
		frame_q.push_back(version);
		frame_q.push_back(ptype);
		frame_q.push_back(flags);
		frame_q.push_back($urandom_range(0, 255));
		for (i = 3; i >= 0; i--)
			frame_q.push_back(stream[8*i +: 8]);
		for (i = 7; i >= 0; i--)
			frame_q.push_back(seq[8*i +: 8]);
		for (i = 3; i >= 0; i--)
			frame_q.push_back(len_field[8*i +: 8]);
	endtask

	task automatic add_payload(input int n);
		repeat (n) frame_q.push_back($urandom_range(0, 255));
	endtask

	task automatic good_frame(input logic [7:0] ptype, input logic [63:0] seq,
			input int n);
		make_header(MAGIC_VALUE, VERSION_VALUE, ptype, $urandom, $urandom, seq, n);
		add_payload(n);
		if (ptype == TYPE_DATA)
			seq_track = seq + 64'd1;
		send_frame();
	endtask

	task automatic random_frame();
		int          pick;
		int          n;
		int          cut;
		int          sel;
		logic [7:0]  ptype;
		logic [63:0] seq;
		logic [31:0] magic;
		logic [7:0]  version;
		logic [31:0] len_field;
		pick = $urandom_range(0, 99);
		sel = $urandom_range(0, 99);
		n = (sel < 60) ? $urandom_range(0, 12) :
			(sel < 92) ? $urandom_range(13, 64) : $urandom_range(65, 300);
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3: ptype = TYPE_DATA;
			4: ptype = TYPE_PING;
			5: ptype = TYPE_CRYPT_HI;
			6: ptype = $urandom_range(TYPE_CRYPT_LO, TYPE_CRYPT_HI);
			default: ptype = $urandom_range(0, 255);
		endcase
		sel = $urandom_range(0, 9);
		case (sel)
			4, 5: seq = seq_track + $urandom_range(1, 6);
			6: seq = seq_track - $urandom_range(1, 3);
			7: seq = {$urandom, $urandom};
			8: seq = '1;
			9: seq = '0;
			default: seq = seq_track;
		endcase
		magic = MAGIC_VALUE;
		version = VERSION_VALUE;
		len_field = n;
		if (pick < 8) begin
			magic = ($urandom_range(0, 1) == 0) ? magic ^ (32'h1 << $urandom_range(0, 31))
				: $urandom;
		end else if (pick < 14) begin
			version = $urandom_range(0, 255);
			if (version == VERSION_VALUE)
				version = 8'h02;
		end else if (pick < 24) begin
			sel = $urandom_range(0, 3);
			case (sel)
				0: len_field = n + 1;
				1: len_field = (n > 0) ? n - 1 : n + 2;
				2: len_field = $urandom;
				default: len_field = n | (32'h1 << $urandom_range(11, 31));
			endcase
		end
		make_header(magic, version, ptype, $urandom, $urandom, seq, len_field);
		add_payload(n);
		if (pick >= 24 && pick < 27) begin
			cut = $urandom_range(1, 23);
			while (frame_q.size() > cut) frame_q.pop_back();
		end else if (pick >= 27 && pick < 30) begin
			frame_q.delete();
			add_payload($urandom_range(1, 60));
		end else if (pick >= 30 && ptype == TYPE_DATA) begin
			seq_track = seq + 64'd1;
		end
		random_items += frame_q.size();
		send_frame();
	endtask

	initial begin
		logic [7:0] phase_key[4];
		int         p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames, all-ones key
		write_key(8'hFF);
		frame_q.delete();
		frame_q.push_back(8'hFF);
		send_frame();
		make_header(MAGIC_VALUE, VERSION_VALUE, TYPE_DATA, 8'h00, 32'h0, 64'd9, 32'd0);
		frame_q.pop_back();
		send_frame();
		make_header(MAGIC_VALUE, VERSION_VALUE, TYPE_DATA, 8'hFF, 32'hFFFF_FFFF,
			64'd1, 32'd0);
		send_frame();
		make_header(MAGIC_VALUE, VERSION_VALUE, TYPE_DATA, 8'h00, 32'h0, 64'd5, 32'd2);
		frame_q.push_back(8'h00);
		frame_q.push_back(8'hFF);
		send_frame();
		good_frame(TYPE_DATA, 64'd3, 1);
		good_frame(TYPE_PING, {$urandom, $urandom}, 2);
		good_frame(TYPE_CRYPT_HI, 64'd0, 2);
		good_frame(TYPE_CRYPT_LO - 8'd1, 64'd0, 2);
		good_frame(TYPE_CRYPT_HI + 8'd1, 64'd0, 2);
		good_frame(8'hFF, '1, 1);
		good_frame(8'h00, 64'd0, 1);
		make_header(MAGIC_VALUE ^ 32'h8000_0001, VERSION_VALUE, TYPE_DATA, 8'h5A,
			32'h1234_5678, 64'd50, 32'd1);
		add_payload(1);
		send_frame();
		make_header(MAGIC_VALUE, 8'h00, TYPE_PING, 8'h00, 32'h0, 64'd1, 32'd0);
		send_frame();
		make_header(MAGIC_VALUE, 8'hFF, TYPE_DATA, 8'h00, 32'h0, 64'd1, 32'd3);
		add_payload(2);
		send_frame();
		make_header(MAGIC_VALUE, VERSION_VALUE, TYPE_DATA, 8'h00, 32'h0, 64'd80, 32'd3);
		add_payload(2);
		send_frame();
		make_header(MAGIC_VALUE, VERSION_VALUE, TYPE_PING, 8'h00, 32'h0, 64'd1,
			32'hFFFF_FFFF);
		send_frame();
		good_frame(TYPE_DATA, '1, 1);
		good_frame(TYPE_DATA, 64'd0, 0);
		// truncated receive: bytes past the buffer size are dropped
		make_header(MAGIC_VALUE, VERSION_VALUE, TYPE_DATA, 8'h00, 32'h0, 64'd7,
			MAX_DATAGRAM_BYTES_DEF - 24);
		add_payload(MAX_DATAGRAM_BYTES_DEF - 22);
		send_frame();
		make_header(32'h0, 8'h00, TYPE_DATA, 8'h00, 32'h0, 64'd1, 32'd0);
		while (frame_q.size() > 10) frame_q.pop_back();
		send_frame();

		phase_key[0] = 8'h00;
		phase_key[1] = $urandom_range(1, 254);
		phase_key[2] = 8'hFF;
		phase_key[3] = $urandom_range(0, 255);
		for (p = 0; p < 4; p++) begin
			write_key(phase_key[p]);
			while (random_items < 10 * (p + 1)) begin
				if ($urandom_range(0, 14) == 0)
					drain_results();
				random_frame();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (mismatch_total == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
